// ===== rtl/core/sd_four_lane_data_crc_macros.svh =====
// Assertion macros for the four-lane SD data CRC block.
`ifndef SD_FOUR_LANE_DATA_CRC_MACROS_SVH
`define SD_FOUR_LANE_DATA_CRC_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SDCRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdcrc assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define SDCRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdcrc assertion failed");

`endif

// ===== rtl/core/sdcrc_pkg.sv =====
// Shared types, constants and CRC functions for the four-lane SD data CRC block.
`timescale 1ns / 1ps
package sdcrc_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CRC_W          = 16;
  localparam int unsigned LANES          = 4;
  localparam int unsigned CRC_BEATS      = 8;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  typedef logic [LANES-1:0][CRC_W-1:0] lanes_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    lanes_t            crc;
  } entry_t;

  function automatic logic [CRC_W-1:0] crc_feed_bit(input logic [CRC_W-1:0] crc,
                                                    input logic bit_in);
    logic fb;
    fb = crc[CRC_W-1] ^ bit_in;
    return {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
  endfunction

  // Each lane w takes data bit 4+w first, then data bit w.
  function automatic lanes_t crc_byte_update(input lanes_t crc, input logic [BYTE_W-1:0] data);
    lanes_t nxt;
    for (int w = 0; w < LANES; w++) begin
      nxt[w] = crc_feed_bit(crc_feed_bit(crc[w], data[LANES + w]), data[w]);
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/sdcrc_front.sv =====
// Front end: accepts data beats, updates the per-lane CRCs and queues work entries.
`timescale 1ns / 1ps
module sdcrc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output sdcrc_pkg::entry_t     push_entry_o
);
  import sdcrc_pkg::*;

  lanes_t lane_crc_q, lane_crc_d;
  lanes_t crc_upd;
  logic   fire;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign fire         = in_valid_i && push_ready_i;

  always_comb begin
    crc_upd            = crc_byte_update(lane_crc_q, data_byte_i);
    push_entry_o.data  = data_byte_i;
    push_entry_o.last  = last_byte_i;
    push_entry_o.crc   = crc_upd;
    lane_crc_d         = lane_crc_q;
    if (fire) begin
      lane_crc_d = last_byte_i ? '0 : crc_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_crc_q <= '0;
    end else begin
      lane_crc_q <= lane_crc_d;
    end
  end

endmodule

// ===== rtl/core/sdcrc_fifo.sv =====
// Short queue of work entries between the front and back ends.
`timescale 1ns / 1ps
module sdcrc_fifo #(
  parameter int unsigned Depth = sdcrc_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sdcrc_pkg::entry_t push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output sdcrc_pkg::entry_t pop_entry_o
);
  import sdcrc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/core/sdcrc_back.sv =====
// Back end: sends each data beat, then the eight interleaved CRC beats after a last byte.
`timescale 1ns / 1ps
module sdcrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  sdcrc_pkg::entry_t pop_entry_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              is_crc_o,
  output logic              block_end_o
);
  import sdcrc_pkg::*;

  localparam int unsigned CntW = $clog2(CRC_BEATS);
  localparam logic [CntW-1:0] LAST_BEAT = CntW'(CRC_BEATS - 1);

  localparam logic ST_DATA = 1'b0;
  localparam logic ST_TAIL = 1'b1;

  logic              state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  lanes_t            snap_q, snap_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              is_crc_q, is_crc_d;
  logic              block_end_q, block_end_d;
  logic              slot_free;
  logic [BYTE_W-1:0] tail_byte;
  lanes_t            snap_shift;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = slot_free && (state_q == ST_DATA);

  // Top two bits of each lane: high nibble from bit 15, low nibble from bit 14.
  always_comb begin
    for (int w = 0; w < LANES; w++) begin
      tail_byte[LANES + w] = snap_q[w][CRC_W-1];
      tail_byte[w]         = snap_q[w][CRC_W-2];
      snap_shift[w]        = {snap_q[w][CRC_W-3:0], 2'b00};
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    snap_d      = snap_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    is_crc_d    = is_crc_q;
    block_end_d = block_end_q;
    if (slot_free) begin
      unique case (state_q)
        ST_DATA: begin
          if (pop_valid_i) begin
            out_valid_d = 1'b1;
            out_byte_d  = pop_entry_i.data;
            is_crc_d    = 1'b0;
            block_end_d = 1'b0;
            if (pop_entry_i.last) begin
              state_d = ST_TAIL;
              snap_d  = pop_entry_i.crc;
              cnt_d   = '0;
            end
          end
        end
        ST_TAIL: begin
          out_valid_d = 1'b1;
          out_byte_d  = tail_byte;
          is_crc_d    = 1'b1;
          block_end_d = (cnt_q == LAST_BEAT);
          snap_d      = snap_shift;
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == LAST_BEAT) begin
            state_d = ST_DATA;
          end
        end
        default: state_d = ST_DATA;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DATA;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q      <= snap_d;
    out_byte_q  <= out_byte_d;
    is_crc_q    <= is_crc_d;
    block_end_q <= block_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_crc_o    = is_crc_q;
  assign block_end_o = block_end_q;

endmodule

// ===== rtl/core/sd_four_lane_data_crc.sv =====
// A data beat passes the queue, then the output register; throughput is one byte per cycle
// in and out unless the output stalls. A last byte adds eight CRC beats on the output, set
// by the single output register, and input stalls once the queue fills.
// Queue holds FifoDepth entries, each carrying the four lane CRCs after its byte.
// Reset (rst_ni low, asynchronous) clears the running lane CRCs, the queue and the output valid.
`timescale 1ns / 1ps
module sd_four_lane_data_crc #(
  parameter int unsigned FifoDepth = sdcrc_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_crc_o,
  output logic       block_end_o
);
  import sdcrc_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_entry, pop_entry;

  sdcrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  sdcrc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  sdcrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_crc_o    (is_crc_o),
    .block_end_o (block_end_o)
  );

endmodule

// ===== rtl/core/sdcrc_checker.sv =====
// Port-level assertion checker for the four-lane SD data CRC block, with its bind.
`timescale 1ns / 1ps
`include "sd_four_lane_data_crc_macros.svh"
module sdcrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_crc_o,
  input logic       block_end_o
);

  logic       out_beat;
  logic [8:0] in_word;
  logic [9:0] out_word;
  assign out_beat = out_valid_o && out_ready_i;
  assign in_word  = {data_byte_i, last_byte_i};
  assign out_word = {out_byte_o, is_crc_o, block_end_o};

  `SDCRC_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_word))
  `SDCRC_ASSERT_IMPL(a_end_is_crc, out_valid_o && block_end_o, is_crc_o)
  `SDCRC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word))
  `SDCRC_ASSERT_NEXT(a_tail_runs, out_beat && is_crc_o && !block_end_o, out_valid_o && is_crc_o)
  `SDCRC_ASSERT_NEXT(a_tail_ends, out_beat && block_end_o, !(out_valid_o && is_crc_o))

endmodule

bind sd_four_lane_data_crc sdcrc_checker u_sdcrc_checker (.*);
